[src/srr_pkg.sv]
// Package for the selective-repeat receiver: transaction types, widths and codes.
// Used by srr_cell and selective_repeat_receiver_top. No dependencies.
package srr_pkg;

  localparam int SEQ_W        = 3;
  localparam int SEQ_SPACE    = 8;
  localparam int DIST_W       = SEQ_W + 1;
  localparam int PAYLOAD_W    = 64;
  localparam int PAYLOAD_BITS = 64;

  localparam logic [PAYLOAD_W-1:0] PAYLOAD_MASK =
    (PAYLOAD_BITS >= PAYLOAD_W) ? {PAYLOAD_W{1'b1}}
                                : ((PAYLOAD_W'(1) << PAYLOAD_BITS) - PAYLOAD_W'(1));

  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  typedef struct packed {
    logic [SEQ_W-1:0]     seq_number;
    logic                 checksum_ok;
    logic [PAYLOAD_W-1:0] payload;
  } pkt_t;

  typedef struct packed {
    logic                 result_kind;
    logic [SEQ_W-1:0]     ack_number;
    logic [PAYLOAD_W-1:0] delivered_data;
    logic                 last;
  } res_t;

  // Contents of one receive-window slot, as held in a cell and passed down the chain.
  typedef struct packed {
    logic                 filled;
    logic [PAYLOAD_W-1:0] data;
  } slot_t;

endpackage

[src/selective_repeat_receiver_top.sv]
// Top level of the selective-repeat ARQ receiver: control, sequence tracking, cell chain.
// Depends on srr_pkg and srr_cell.
//
// The receiver takes one packet transaction at a time on the pkt channel and
// produces result transactions on the res channel, one per cycle at most. A packet
// with a bad checksum is dropped and gives no result. An out-of-order packet inside
// the window is stored in its slot and acknowledged; any other packet that is not
// the expected one is acknowledged again as a duplicate. The packet carrying the
// expected sequence number is acknowledged and then it and the contiguous run of
// stored packets behind it are delivered in order. The run is paced by the single
// result register, which moves one transaction per cycle unless the result side
// stalls, and by the slot cells, which form a chain that shifts by one slot for
// every delivered payload while the expected number steps by one.
// No new packet is taken while a delivery run is in progress or while the result
// register is full and stalled. The window depth is the WINDOW parameter (1 to
// SEQ_SPACE); slot cell k holds the packet numbered expected + k modulo the
// sequence space.
module selective_repeat_receiver_top #(
  parameter int WINDOW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          pkt_valid,
  output logic          pkt_stall,
  input  srr_pkg::pkt_t pkt,
  output logic          res_valid,
  input  logic          res_stall,
  output srr_pkg::res_t res
);
  import srr_pkg::*;

  localparam logic [0:0] ST_IDLE    = 1'b0;
  localparam logic [0:0] ST_DELIVER = 1'b1;

  logic [0:0]        state;
  logic [0:0]        state_next;
  logic [SEQ_W-1:0]  expected_seq;
  logic [SEQ_W-1:0]  expected_seq_next;

  slot_t             slot     [WINDOW];
  slot_t             neighbor [WINDOW];
  logic [WINDOW-1:0] load;
  logic              shift;

  logic              out_free;
  logic              accept;
  logic              accept_ok;
  logic              seq_match;
  logic              seq_legal;
  logic [DIST_W-1:0] seq_ext;
  logic [DIST_W-1:0] exp_ext;
  logic [DIST_W-1:0] ahead;
  logic [PAYLOAD_W-1:0] pkt_data;

  // The result register can take a new transaction when empty or being drained.
  assign out_free  = !res_valid || !res_stall;
  assign pkt_stall = (state != ST_IDLE) || !out_free;
  assign accept    = pkt_valid && !pkt_stall;
  assign accept_ok = accept && pkt.checksum_ok;

  assign pkt_data  = pkt.payload & PAYLOAD_MASK;
  assign seq_match = (pkt.seq_number == expected_seq);
  assign seq_ext   = {1'b0, pkt.seq_number};
  assign exp_ext   = {1'b0, expected_seq};
  assign seq_legal = (seq_ext < DIST_W'(SEQ_SPACE));

  // Distance of the packet ahead of the expected number, modulo the sequence space.
  always_comb begin
    if (seq_ext >= exp_ext) begin
      ahead = seq_ext - exp_ext;
    end else begin
      ahead = seq_ext + DIST_W'(SEQ_SPACE) - exp_ext;
    end
  end

  // Each delivery in the run moves the chain down by one slot.
  assign shift = (state == ST_DELIVER) && out_free;

  // The expected packet always lands in the head cell; an early packet lands in its
  // own cell only if that cell is still empty, so a stored payload is never replaced.
  genvar gi;
  generate
    for (gi = 0; gi < WINDOW; gi++) begin : g_chain
      if (gi == 0) begin : g_head
        assign load[gi] = accept_ok && seq_match;
      end else begin : g_body
        assign load[gi] = accept_ok && !seq_match && seq_legal && !slot[gi].filled &&
                          ({{(32-DIST_W){1'b0}}, ahead} == 32'(gi));
      end

      if (gi == WINDOW - 1) begin : g_tail
        assign neighbor[gi] = '{filled: 1'b0, data: '0};
      end else begin : g_link
        assign neighbor[gi] = slot[gi+1];
      end

      srr_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (shift),
        .load      (load[gi]),
        .load_data (pkt_data),
        .neighbor  (neighbor[gi]),
        .slot      (slot[gi])
      );
    end
  endgenerate

  always_comb begin
    state_next        = state;
    expected_seq_next = expected_seq;
    case (state)
      ST_IDLE: begin
        if (accept_ok && seq_match) begin
          state_next = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (out_free) begin
          if (expected_seq == SEQ_W'(SEQ_SPACE - 1)) begin
            expected_seq_next = '0;
          end else begin
            expected_seq_next = expected_seq + SEQ_W'(1);
          end
          // The run ends when the slot moving into the head is empty.
          if (!neighbor[0].filled) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      expected_seq <= '0;
    end else begin
      state        <= state_next;
      expected_seq <= expected_seq_next;
    end
  end

  // Result register: an acknowledgment on an accepted good packet, then the
  // deliveries of the run, each taken from the head cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept_ok || shift) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_ok) begin
      res.result_kind    <= KIND_ACK;
      res.ack_number     <= pkt.seq_number;
      res.delivered_data <= '0;
      res.last           <= !seq_match;
    end else if (shift) begin
      res.result_kind    <= KIND_DATA;
      res.ack_number     <= '0;
      res.delivered_data <= slot[0].data;
      res.last           <= !neighbor[0].filled;
    end
  end

  // A delivery run always starts from a filled head cell.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DELIVER) |-> slot[0].filled)
    else $error("delivery run with an empty head slot");

  // The held result is the final one of its packet exactly when the block is idle.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.last == (state == ST_IDLE)))
    else $error("last flag out of step with the delivery run");

  // The expected number moves only while payloads are being delivered.
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_DELIVER) |=> $stable(expected_seq))
    else $error("expected sequence number changed outside a delivery run");

  // No packet is taken while a run is in progress.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DELIVER) |-> !accept)
    else $error("packet accepted during a delivery run");

endmodule

[src/srr_cell.sv]
// One receive-window slot cell of the selective-repeat receiver.
// Depends on srr_pkg for slot_t.
module srr_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    shift,
  input  logic                    load,
  input  logic [srr_pkg::PAYLOAD_W-1:0] load_data,
  input  srr_pkg::slot_t          neighbor,
  output srr_pkg::slot_t          slot
);
  import srr_pkg::*;

  // A shift takes the neighbor's contents; otherwise a load fills the slot.
  // Only the valid bit is reset; the payload is meaningful once the slot is filled.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot.filled <= 1'b0;
    end else if (shift) begin
      slot.filled <= neighbor.filled;
      slot.data   <= neighbor.data;
    end else if (load) begin
      slot.filled <= 1'b1;
      slot.data   <= load_data;
    end
  end

endmodule

[verif/selective_repeat_receiver_top_test.sv]
// Self-checking testbench for selective_repeat_receiver_top, the selective-repeat ARQ receiver.
// Depends on srr_pkg and the receiver RTL; an internal predictor computes every expected result.
`timescale 1ns / 100ps

module selective_repeat_receiver_top_test;

  import srr_pkg::*;

  localparam int WINDOW      = 4;
  localparam int HOLD_CYCLES = 150;
  localparam int TAIL_CYCLES = 24;
  localparam int CYCLE_LIMIT = 200000;

  // Stimulus phases, each with its own idling profile on the two channels.
  typedef enum logic [2:0] {
    PH_FREE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_PRESSURE,
    PH_BOTH
  } phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pkt_valid = 1'b0;
  logic pkt_stall;
  pkt_t pkt = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  selective_repeat_receiver_top #(
    .WINDOW(WINDOW)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .pkt_valid(pkt_valid),
    .pkt_stall(pkt_stall),
    .pkt      (pkt),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

  // 12 ns clock period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Packets waiting to be offered, and results the predictor says must come back.
  pkt_t pkt_queue[$];
  res_t expected_res[$];

  // The predictor's copy of the receiver state: the awaited sequence number and
  // the receive window, slot k standing for sequence number exp_seq + k.
  logic [SEQ_W-1:0]     exp_seq = '0;
  logic                 win_full[WINDOW];
  logic [PAYLOAD_W-1:0] win_data[WINDOW];

  phase_t           phase = PH_FREE;
  int               send_idle_pct = 0;
  int               stall_pct = 0;
  logic             hold_on = 1'b0;
  logic [SEQ_W-1:0] gen_base = '0;

  int pushed_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int full_runs = 0;
  int error_count = 0;
  int cycle_count = 0;

  initial begin
    for (int i = 0; i < WINDOW; i++) begin
      win_full[i] = 1'b0;
      win_data[i] = '0;
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("mismatch: %s", msg);
  endtask

  task automatic push_pkt(input logic [SEQ_W-1:0] seq, input logic ok,
                          input logic [PAYLOAD_W-1:0] data);
    pkt_t p;
    p.seq_number  = seq;
    p.checksum_ok = ok;
    p.payload     = data;
    pkt_queue.push_back(p);
    pushed_count++;
  endtask

  // Advances the predicted state by one accepted packet and queues the results it causes.
  task automatic predict_packet(input pkt_t p);
    res_t r;
    int   run;
    int   ahead;
    if (!p.checksum_ok) return;
    if (p.seq_number == exp_seq) begin
      win_full[0] = 1'b1;
      win_data[0] = p.payload & PAYLOAD_MASK;
      run = 0;
      while (run < WINDOW && win_full[run]) run++;
      if (run == WINDOW) full_runs++;
      r = '0;
      r.result_kind = KIND_ACK;
      r.ack_number  = p.seq_number;
      expected_res.push_back(r);
      for (int k = 0; k < run; k++) begin
        r = '0;
        r.result_kind    = KIND_DATA;
        r.delivered_data = win_data[k];
        r.last           = (k == run - 1);
        expected_res.push_back(r);
      end
      // The window slides by the number of payloads delivered.
      for (int i = 0; i < WINDOW; i++) begin
        if (i + run < WINDOW) begin
          win_full[i] = win_full[i + run];
          win_data[i] = win_data[i + run];
        end else begin
          win_full[i] = 1'b0;
          win_data[i] = '0;
        end
      end
      exp_seq = SEQ_W'((int'(exp_seq) + run) % SEQ_SPACE);
    end else begin
      ahead = (int'(p.seq_number) + SEQ_SPACE - int'(exp_seq)) % SEQ_SPACE;
      if (ahead >= 1 && ahead < WINDOW && !win_full[ahead]) begin
        win_full[ahead] = 1'b1;
        win_data[ahead] = p.payload & PAYLOAD_MASK;
      end
      r = '0;
      r.result_kind = KIND_ACK;
      r.ack_number  = p.seq_number;
      r.last        = 1'b1;
      expected_res.push_back(r);
    end
  endtask

  // Queues random traffic until `target` packets with a good checksum have been made.
  // Most of it is windows sent out of order, with corrupted copies and retransmissions
  // mixed in, so the receiver spends its time buffering and delivering. The rest is
  // noise outside the window, which never moves the receiver state.
  task automatic gen_random(input int target);
    int               made;
    int               n;
    int               j;
    int               tmp;
    int               order[WINDOW];
    logic             ok;
    logic [SEQ_W-1:0] s;
    made = 0;
    while (made < target) begin
      if ($urandom_range(99) < 15) begin
        s  = gen_base + SEQ_W'($urandom_range(SEQ_SPACE - 1, WINDOW));
        ok = 1'($urandom_range(1));
        push_pkt(s, ok, {$urandom, $urandom});
        if (ok) made++;
      end else begin
        n = $urandom_range(WINDOW, 1);
        for (int i = 0; i < n; i++) order[i] = i;
        for (int i = n - 1; i > 0; i--) begin
          j = $urandom_range(i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        for (int i = 0; i < n; i++) begin
          s = gen_base + SEQ_W'(order[i]);
          if ($urandom_range(99) < 10) push_pkt(s, 1'b0, {$urandom, $urandom});
          push_pkt(s, 1'b1, {$urandom, $urandom});
          made++;
          if ($urandom_range(99) < 10) begin
            push_pkt(s, 1'b1, {$urandom, $urandom});
            made++;
          end
        end
        gen_base = gen_base + SEQ_W'(n);
      end
    end
  endtask

  // Driver: keeps a stalled transaction steady and only moves to the next packet
  // once the current one has been taken.
  always @(posedge clk) begin
    if (rst) begin
      pkt_valid <= 1'b0;
    end else begin
      if (pkt_valid && !pkt_stall) begin
        predict_packet(pkt);
        sent_count++;
      end
      if (!pkt_valid || !pkt_stall) begin
        if (pkt_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          pkt       <= pkt_queue.pop_front();
          pkt_valid <= 1'b1;
        end else begin
          pkt_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction, and
  // drives the result-side stall for the next cycle.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_res.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: kind %0d ack %0d data %h",
                                    res.result_kind, res.ack_number, res.delivered_data));
        end else begin
          want = expected_res.pop_front();
          checked_count++;
          if (res.result_kind !== want.result_kind)
            report_mismatch($sformatf("result %0d kind %0d, expected %0d", checked_count,
                                      res.result_kind, want.result_kind));
          if (res.ack_number !== want.ack_number)
            report_mismatch($sformatf("result %0d ack %0d, expected %0d", checked_count,
                                      res.ack_number, want.ack_number));
          if (res.delivered_data !== want.delivered_data)
            report_mismatch($sformatf("result %0d data %h, expected %h", checked_count,
                                      res.delivered_data, want.delivered_data));
          if (res.last !== want.last)
            report_mismatch($sformatf("result %0d last %0d, expected %0d", checked_count,
                                      res.last, want.last));
        end
      end
      res_stall <= hold_on || ($urandom_range(99) < stall_pct);
    end
  end

  // Long hold-off on the result side. The sender keeps offering packets meanwhile,
  // so the result register fills and the receiver has to stall its input.
  initial begin
    wait (phase == PH_PRESSURE);
    @(negedge clk);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_on = 1'b0;
  end

  // Watchdog for a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // Stimulus: reset, a directed sequence, then random traffic phase by phase.
  initial begin
    rst = 1'b1;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Directed part, starting from an expected number of zero.
    push_pkt(3'd0, 1'b0, {PAYLOAD_W{1'b1}});     // corrupted packet at the expected number
    push_pkt(3'd1, 1'b1, '0);                    // buffered one ahead
    push_pkt(3'd1, 1'b1, {32{2'b10}});           // slot already filled, old payload kept
    push_pkt(3'd3, 1'b1, {PAYLOAD_W{1'b1}});     // buffered at the far edge of the window
    push_pkt(3'd4, 1'b1, {32{2'b01}});           // just outside the window
    push_pkt(3'd7, 1'b1, 64'd1);                 // behind the window, a stale duplicate
    push_pkt(3'd0, 1'b1, 64'h0123_4567_89ab_cdef); // delivers 0 and 1
    push_pkt(3'd2, 1'b1, 64'hfedc_ba98_7654_3210); // delivers 2 and the buffered 3
    push_pkt(3'd5, 1'b1, 64'h8000_0000_0000_0001);
    push_pkt(3'd6, 1'b1, 64'h7fff_ffff_ffff_fffe);
    push_pkt(3'd7, 1'b1, 64'h00ff_00ff_00ff_00ff);
    push_pkt(3'd4, 1'b1, 64'hff00_ff00_ff00_ff00); // full window: ack plus four deliveries
    push_pkt(3'd0, 1'b0, 64'h1111_2222_3333_4444); // corrupted after wrapping to zero
    push_pkt(3'd3, 1'b1, 64'haaaa_5555_aaaa_5555);
    push_pkt(3'd2, 1'b1, 64'h5555_aaaa_5555_aaaa);
    push_pkt(3'd1, 1'b1, 64'hdead_beef_cafe_f00d);
    push_pkt(3'd0, 1'b1, 64'h0f0f_0f0f_0f0f_0f0f);
    push_pkt(3'd4, 1'b1, {PAYLOAD_W{1'b1}});      // single in-order delivery
    push_pkt(3'd5, 1'b1, '0);
    gen_base = 3'd6;

    gen_random(28);
    while (pkt_queue.size() > 0) @(negedge clk);

    phase = PH_SEND_IDLE;
    send_idle_pct = 74;
    stall_pct = 0;
    gen_random(28);
    while (pkt_queue.size() > 0) @(negedge clk);

    phase = PH_RECV_STALL;
    send_idle_pct = 0;
    stall_pct = 74;
    gen_random(28);
    while (pkt_queue.size() > 0) @(negedge clk);

    phase = PH_PRESSURE;
    send_idle_pct = 0;
    stall_pct = 0;
    gen_random(17);
    while (pkt_queue.size() > 0 || hold_on) @(negedge clk);

    phase = PH_BOTH;
    send_idle_pct = 24;
    stall_pct = 24;
    gen_random(28);

    // Drain: every packet taken, every predicted result seen, then a short tail
    // in which any stray result would be caught by the monitor.
    while (sent_count < pushed_count || expected_res.size() > 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("run covered %0d packets and %0d checked results, %0d full-window deliveries",
             sent_count, checked_count, full_runs);
    $display("idling phases: none, sender idle, receiver stalling, long hold-off, both");
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", error_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
src/srr_pkg.sv
src/srr_cell.sv
src/selective_repeat_receiver_top.sv
verif/selective_repeat_receiver_top_test.sv
